// ----- rtl/number_to_seven_segment_writes_macros.svh -----
// assertion macros used by the port-level checker in ntss_checker.sv
`ifndef NUMBER_TO_SEVEN_SEGMENT_WRITES_MACROS_SVH
`define NUMBER_TO_SEVEN_SEGMENT_WRITES_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NTSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ntss_pkg.sv -----
// types, constants and the digit table of the seven-segment writer
`timescale 1ns / 1ps

package ntss_pkg;

  typedef logic [7:0]       seg_t;
  typedef logic [3:0][7:0]  segs_t;
  typedef logic [5:0]       addr_t;

  localparam seg_t        SegBlank  = 8'h00;
  localparam seg_t        SegE      = 8'h79;
  localparam seg_t        SegR      = 8'h50;
  localparam addr_t       AddrBase  = 6'h34;
  localparam logic [15:0] MaxShown  = 16'd9999;

  // digit to segment pattern, point off
  function automatic seg_t digit_seg(input logic [3:0] d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/number_to_seven_segment_writes.sv -----
// top level: number in, four display register writes out
// a number is taken when start is high and busy low, into an input register
// its first word goes out once the number has moved on into the output register, then one word per cycle
// four words per number; the receiver cannot stall
// the next number waits in the input register while the current one drains
// reset clears both valid flags, so no word goes out until a number arrives
`timescale 1ns / 1ps

module number_to_seven_segment_writes (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         number_value_i,
  output logic                strobe_o,
  output logic [5:0]          register_address_o,
  output logic [7:0]          segment_byte_o,
  output logic                last_write_o
);

  logic            num_vld_q, num_vld_d;
  logic [15:0]     num_q;
  logic            accept;
  logic            load;
  logic            out_free;
  ntss_pkg::segs_t segs;

  assign busy   = num_vld_q && !out_free;
  assign accept = start && !busy;
  assign load   = num_vld_q && out_free;

  always_comb begin
    num_vld_d = num_vld_q;
    if (accept) begin
      num_vld_d = 1'b1;
    end else if (load) begin
      num_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else begin
      num_vld_q <= num_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= number_value_i;
    end
  end

  ntss_decode u_decode (
    .num_i  (num_q),
    .segs_o (segs)
  );

  ntss_out u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (load),
    .segs_i             (segs),
    .free_o             (out_free),
    .strobe_o           (strobe_o),
    .register_address_o (register_address_o),
    .segment_byte_o     (segment_byte_o),
    .last_write_o       (last_write_o)
  );

endmodule

// ----- rtl/ntss_decode.sv -----
// binary to four-digit segment patterns with blanking and error pattern
`timescale 1ns / 1ps

module ntss_decode (
  input  logic [15:0]         num_i,
  output ntss_pkg::segs_t     segs_o
);

  logic [13:0] v;
  logic [27:0] p1000, p100, p10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [3:0]  d3, d2, d1, d0;
  logic        err;

  assign v = num_i[13:0];

  // reciprocal multiplies, exact for values up to 9999
  assign p1000 = 28'(v) * 28'd8389;
  assign p100  = 28'(v) * 28'd5243;
  assign p10   = 28'(v) * 28'd6554;

  assign q1000 = p1000[26:23];
  assign q100  = p100[25:19];
  assign q10   = p10[25:16];

  // each digit is below ten, so four bits of the remainder suffice
  assign d3 = q1000;
  assign d2 = q100[3:0] - 4'(q1000 * 4'd10);
  assign d1 = q10[3:0]  - 4'(q100[3:0] * 4'd10);
  assign d0 = v[3:0]    - 4'(q10[3:0] * 4'd10);

  assign err = num_i > ntss_pkg::MaxShown;

  always_comb begin
    if (err) begin
      segs_o[0] = ntss_pkg::SegE;
      segs_o[1] = ntss_pkg::SegR;
      segs_o[2] = ntss_pkg::SegR;
      segs_o[3] = ntss_pkg::SegBlank;
    end else begin
      segs_o[0] = (num_i >= 16'd1000) ? ntss_pkg::digit_seg(d3) : ntss_pkg::SegBlank;
      segs_o[1] = (num_i >= 16'd100)  ? ntss_pkg::digit_seg(d2) : ntss_pkg::SegBlank;
      segs_o[2] = (num_i >= 16'd10)   ? ntss_pkg::digit_seg(d1) : ntss_pkg::SegBlank;
      segs_o[3] = ntss_pkg::digit_seg(d0);
    end
  end

endmodule

// ----- rtl/ntss_out.sv -----
// result register that sends the four display writes one per cycle
`timescale 1ns / 1ps

module ntss_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ntss_pkg::segs_t     segs_i,
  output logic                free_o,
  output logic                strobe_o,
  output ntss_pkg::addr_t     register_address_o,
  output ntss_pkg::seg_t      segment_byte_o,
  output logic                last_write_o
);

  logic            active_q, active_d;
  logic [1:0]      idx_q, idx_d;
  ntss_pkg::segs_t segs_q, segs_d;

  // free when idle or while the last word of the current number goes out
  assign free_o = !active_q || (idx_q == 2'd3);

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    segs_d   = segs_q;
    if (load_i) begin
      active_d = 1'b1;
      idx_d    = 2'd0;
      segs_d   = segs_i;
    end else if (active_q) begin
      if (idx_q == 2'd3) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    segs_q <= segs_d;
  end

  assign strobe_o           = active_q;
  assign register_address_o = ntss_pkg::AddrBase + 6'(idx_q);
  assign segment_byte_o     = segs_q[idx_q];
  assign last_write_o       = active_q && (idx_q == 2'd3);

endmodule

// ----- rtl/ntss_checker.sv -----
// port-level checks on the display write sequence, bound to the top level
`timescale 1ns / 1ps
`include "number_to_seven_segment_writes_macros.svh"

module ntss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        strobe_o,
  input logic [5:0]  register_address_o,
  input logic [7:0]  segment_byte_o,
  input logic        last_write_o
);

  // a number's four words go out back to back
  `NTSS_ASSERT_NEXT(a_words_contiguous, clk_i, rst_ni, strobe_o && !last_write_o, strobe_o, "word sequence broken")

  // addresses step by one within a number
  `NTSS_ASSERT_NEXT(a_addr_step, clk_i, rst_ni, strobe_o && !last_write_o, register_address_o == $past(register_address_o) + 6'd1, "address did not step")

  // last word goes to the rightmost digit
  `NTSS_ASSERT_NOW(a_last_addr, clk_i, rst_ni, strobe_o && last_write_o, register_address_o == 6'h37, "last word at wrong address")

  // a leftmost word only starts after idle or after a last word
  `NTSS_ASSERT_NOW(a_first_start, clk_i, rst_ni, strobe_o && (register_address_o == 6'h34), !$past(strobe_o) || $past(last_write_o), "new number cut in early")

  // decimal point stays off
  `NTSS_ASSERT_NOW(a_point_off, clk_i, rst_ni, strobe_o, !segment_byte_o[7], "decimal point set")

endmodule

bind number_to_seven_segment_writes ntss_checker u_ntss_checker (.*);

// ----- tb/ntss_write_checker.sv -----
// checker for the seven-segment writer: predicts display words and compares them
`timescale 1ns / 1ps

module ntss_write_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] number_value_i,
  input  logic        strobe_i,
  input  logic [5:0]  register_address_i,
  input  logic [7:0]  segment_byte_i,
  input  logic        last_write_i,
  output int          mismatch_count_o,
  output int          pending_o,
  output int          words_seen_o
);

  typedef struct packed {
    ntss_pkg::addr_t addr;
    ntss_pkg::seg_t  seg;
    logic            last;
  } disp_write_t;

  localparam ntss_pkg::seg_t DIGIT_PATTERN [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  disp_write_t expected_writes[$];
  int          mismatches = 0;
  int          words_seen = 0;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    words_seen_o     = 0;
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
             exp_val, got_val);
    mismatches++;
  endtask

  // four words per number, leftmost digit first
  function automatic void predict_display_writes(input logic [15:0] num);
    int             value;
    ntss_pkg::seg_t segs [4];
    disp_write_t    w;
    value = int'(num);
    if (num > ntss_pkg::MaxShown) begin
      segs[0] = ntss_pkg::SegE;
      segs[1] = ntss_pkg::SegR;
      segs[2] = ntss_pkg::SegR;
      segs[3] = ntss_pkg::SegBlank;
    end else begin
      // leading positions blank, units digit always shown
      segs[0] = (value >= 1000) ? DIGIT_PATTERN[value / 1000] : ntss_pkg::SegBlank;
      segs[1] = (value >= 100) ? DIGIT_PATTERN[(value / 100) % 10] : ntss_pkg::SegBlank;
      segs[2] = (value >= 10) ? DIGIT_PATTERN[(value / 10) % 10] : ntss_pkg::SegBlank;
      segs[3] = DIGIT_PATTERN[value % 10];
    end
    for (int k = 0; k < 4; k++) begin
      w.addr = ntss_pkg::AddrBase + ntss_pkg::addr_t'(k);
      w.seg  = segs[k];
      w.last = (k == 3);
      expected_writes.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin
    disp_write_t w;
    if (rst_ni) begin
      if (strobe_i) begin
        words_seen++;
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected word, address", 0, int'(register_address_i));
        end else begin
          w = expected_writes.pop_front();
          if (register_address_i !== w.addr)
            report_mismatch("register_address", int'(w.addr), int'(register_address_i));
          if (segment_byte_i !== w.seg)
            report_mismatch("segment_byte", int'(w.seg), int'(segment_byte_i));
          if (last_write_i !== w.last)
            report_mismatch("last_write", int'(w.last), int'(last_write_i));
        end
      end
      if (start_i && !busy_i)
        predict_display_writes(number_value_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_writes.size();
    words_seen_o     <= words_seen;
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top: drives numbers into the seven-segment writer and gives the verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_RANDOM   = 310;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] number_value_i = '0;
  logic        strobe_o;
  logic [5:0]  register_address_o;
  logic [7:0]  segment_byte_o;
  logic        last_write_o;

  int mismatch_count;
  int pending_words;
  int words_seen;
  int cycle_count = 0;
  int numbers_sent = 0;
  int error_numbers = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  number_to_seven_segment_writes dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .number_value_i     (number_value_i),
    .strobe_o           (strobe_o),
    .register_address_o (register_address_o),
    .segment_byte_o     (segment_byte_o),
    .last_write_o       (last_write_o)
  );

  ntss_write_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .number_value_i     (number_value_i),
    .strobe_i           (strobe_o),
    .register_address_i (register_address_o),
    .segment_byte_i     (segment_byte_o),
    .last_write_i       (last_write_o),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_words),
    .words_seen_o       (words_seen)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_words);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called right after a rising edge; returns after acceptance and any idle gap
  task automatic send_number(input logic [15:0] num, input bit allow_idle);
    int gap;
    gap = 0;
    start          <= 1'b1;
    number_value_i <= num;
    do @(posedge clk_i); while (busy);
    numbers_sent++;
    if (num > ntss_pkg::MaxShown) error_numbers++;
    if (allow_idle) begin
      while ($urandom_range(99) < 31) gap++;
    end
    if (gap > 0) begin
      start          <= 1'b0;
      number_value_i <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_written();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_number();
    logic [15:0] n;
    case ($urandom_range(9))
      0:       n = 16'($urandom_range(9));
      1:       n = 16'($urandom_range(99, 10));
      2:       n = 16'($urandom_range(999, 100));
      3, 4:    n = 16'($urandom_range(9999, 1000));
      5:       n = 16'($urandom_range(65535, 10000));
      6:       n = 16'($urandom);
      7: begin
        case ($urandom_range(9))
          0: n = 16'd0;
          1: n = 16'd9;
          2: n = 16'd10;
          3: n = 16'd99;
          4: n = 16'd100;
          5: n = 16'd999;
          6: n = 16'd1000;
          7: n = 16'd9999;
          8: n = 16'd10000;
          default: n = 16'hFFFF;
        endcase
      end
      default: n = 16'($urandom_range(9999));
    endcase
    return n;
  endfunction

  initial begin
    logic [15:0] directed [$];
    bit          idle_ok;
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'hFFFF, 16'h8000, 16'd1234, 16'd5678,
                 16'd9090, 16'd8888, 16'd4567, 16'd7001, 16'd305, 16'd62,
                 16'hAAAA, 16'h5555, 16'd2468};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_number(directed[i], 1'b1);
    wait_all_written();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // back-to-back stretch keeps the input register full
      idle_ok = !(i >= 100 && i < 170);
      send_number(pick_number(), idle_ok);
      if (i == 220) wait_all_written();
    end

    wait_all_written();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d numbers, %0d of them above the display range", numbers_sent,
             error_numbers);
    $display("checked %0d display words against the prediction", words_seen);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ntss_pkg.sv
rtl/ntss_decode.sv
rtl/ntss_out.sv
rtl/number_to_seven_segment_writes.sv
rtl/ntss_checker.sv
tb/ntss_write_checker.sv
tb/tb_top.sv
